### hw/rtl/uart_rx_pkg.sv
package uart_rx_pkg;

  // configuration register widths and indexes
  localparam int HALF_W  = 16;
  localparam int BITS_W  = 4;
  localparam int PMODE_W = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_HALF_BIT_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_BIT_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PARITY_MODE    = 2'd2;

  localparam logic [HALF_W-1:0]  HALF_RESET  = 16'd1093;
  localparam logic [BITS_W-1:0]  BITS_RESET  = 4'd8;
  localparam logic [BITS_W-1:0]  BITS_MIN    = 4'd5;
  localparam logic [BITS_W-1:0]  BITS_MAX    = 4'd8;

  // parity modes
  localparam logic [PMODE_W-1:0] PAR_NONE = 2'd0;
  localparam logic [PMODE_W-1:0] PAR_EVEN = 2'd1;
  localparam logic [PMODE_W-1:0] PAR_ODD  = 2'd2;

  localparam int TICK_W = 17;
  localparam int BYTE_W = 8;

  // result queue between sampler and output stage
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [HALF_W-1:0]  half_bit_ticks;
    logic [BITS_W-1:0]  data_bit_count;
    logic [PMODE_W-1:0] parity_mode;
  } rx_cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] received_byte;
    logic              frame_status;
    logic              stop_level;
  } rx_result_t;

  typedef struct packed {
    logic       valid;
    rx_result_t result;
  } rx_push_t;

endpackage

### hw/rtl/uart_rx_if.sv
interface uart_rx_in_if;
  logic valid;
  logic ready;
  logic line_level;

  modport source (output valid, output line_level, input ready);
  modport sink   (input valid, input line_level, output ready);
endinterface

interface uart_rx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] received_byte;
  logic       frame_status;
  logic       stop_level;

  modport source (output valid, output received_byte, output frame_status,
                  output stop_level, input ready);
  modport sink   (input valid, input received_byte, input frame_status,
                  input stop_level, output ready);
endinterface

### hw/rtl/uart_rx_front.sv
module uart_rx_front
  import uart_rx_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     beat,
  input  logic     line_level,
  input  rx_cfg_t  cfg,
  output rx_push_t push
);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_START  = 3'd1;
  localparam logic [2:0] PH_DATA   = 3'd2;
  localparam logic [2:0] PH_PARITY = 3'd3;
  localparam logic [2:0] PH_STOP   = 3'd4;

  logic [2:0]        phase_r, phase_nxt;
  logic [TICK_W-1:0] tick_r, tick_nxt;
  logic [BITS_W-1:0] bit_r, bit_nxt;
  logic [BYTE_W-1:0] shift_r, shift_nxt;
  logic              pacc_r, pacc_nxt;
  logic              prx_r, prx_nxt;

  logic [TICK_W-1:0] half_eff, full_eff, target, tick_inc;
  logic [BITS_W-1:0] bits_eff;
  logic              hit, parity_on, expect_bit;

  always_comb begin
    half_eff = (cfg.half_bit_ticks == '0) ? TICK_W'(1) : TICK_W'(cfg.half_bit_ticks);
    full_eff = {half_eff[TICK_W-2:0], 1'b0};
    if (cfg.data_bit_count < BITS_MIN) begin
      bits_eff = BITS_MIN;
    end else if (cfg.data_bit_count > BITS_MAX) begin
      bits_eff = BITS_MAX;
    end else begin
      bits_eff = cfg.data_bit_count;
    end
    parity_on  = (cfg.parity_mode == PAR_EVEN) || (cfg.parity_mode == PAR_ODD);
    target     = (phase_r == PH_START) ? half_eff : full_eff;
    tick_inc   = tick_r + TICK_W'(1);
    hit        = (tick_inc >= target);
    expect_bit = pacc_r ^ (cfg.parity_mode == PAR_ODD);
  end

  always_comb begin
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    pacc_nxt  = pacc_r;
    prx_nxt   = prx_r;
    push.valid = 1'b0;
    push.result.received_byte = shift_r;
    push.result.frame_status  = parity_on && (expect_bit != prx_r);
    push.result.stop_level    = line_level;
    if (beat) begin
      if (phase_r != PH_IDLE) begin
        tick_nxt = hit ? '0 : tick_inc;
      end
      unique case (phase_r)
        PH_START: begin
          if (hit) begin
            if (!line_level) begin
              phase_nxt = PH_DATA;
              bit_nxt   = '0;
              shift_nxt = '0;
              pacc_nxt  = 1'b0;
            end else begin
              phase_nxt = PH_IDLE;
            end
          end
        end
        PH_DATA: begin
          if (hit) begin
            if (bit_r < BITS_W'(BYTE_W)) begin
              shift_nxt = shift_r | (BYTE_W'(line_level) << bit_r[2:0]);
            end
            pacc_nxt = pacc_r ^ line_level;
            bit_nxt  = bit_r + BITS_W'(1);
            if (bit_nxt >= bits_eff) begin
              phase_nxt = parity_on ? PH_PARITY : PH_STOP;
            end
          end
        end
        PH_PARITY: begin
          if (hit) begin
            prx_nxt   = line_level;
            phase_nxt = PH_STOP;
          end
        end
        PH_STOP: begin
          if (hit) begin
            push.valid = 1'b1;
            phase_nxt  = PH_IDLE;
          end
        end
        default: begin
          // idle and unused codes: look for a falling line
          phase_nxt = PH_IDLE;
          if (!line_level) begin
            phase_nxt = PH_START;
            tick_nxt  = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tick_r  <= '0;
      bit_r   <= '0;
      shift_r <= '0;
      pacc_r  <= 1'b0;
      prx_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      pacc_r  <= pacc_nxt;
      prx_r   <= prx_nxt;
    end
  end

  a_push_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |=> (phase_r == PH_IDLE))
    else $error("sampler not idle after frame end");

  a_no_status_without_parity: assert property (@(posedge clk) disable iff (!rst_n)
    (push.valid && !parity_on) |-> !push.result.frame_status)
    else $error("parity error flagged with parity off");

  a_bit_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bit_r <= BITS_MAX)
    else $error("bit index past last data bit");

endmodule

### hw/rtl/uart_rx_fifo.sv
module uart_rx_fifo
  import uart_rx_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  rx_push_t   push,
  input  logic       pop,
  output logic       full,
  output logic       not_empty,
  output rx_result_t head
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  rx_result_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];
  assign do_push   = push.valid && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      count_r <= count_r + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("result queue overfilled");

  a_no_lost_push: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> !full)
    else $error("result pushed into full queue");

  a_empty_no_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (!not_empty && !push.valid) |=> !not_empty)
    else $error("queue filled without a push");

endmodule

### hw/rtl/uart_rx_back.sv
module uart_rx_back
  import uart_rx_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_not_empty,
  input  rx_result_t        q_head,
  output logic              q_pop,
  uart_rx_out_if.source     out_ch
);

  logic       out_valid_r;
  rx_result_t out_data_r;

  // refill the output register whenever it is empty or being taken
  assign q_pop = q_not_empty && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r <= q_head;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.received_byte = out_data_r.received_byte;
  assign out_ch.frame_status  = out_data_r.frame_status;
  assign out_ch.stop_level    = out_data_r.stop_level;

  a_pop_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_valid_r)
    else $error("popped result not presented");

  a_no_pop_while_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !q_pop)
    else $error("output overwritten while stalled");

  a_pop_only_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_not_empty)
    else $error("pop from empty queue");

endmodule

### hw/rtl/uart_receiver_with_parity.sv
// uart receiver with optional parity. every input beat is one clock-tick sample
// of the receive line; the block accepts one beat per cycle and ready stays high
// except when every entry of the result queue is occupied, which needs the
// output register stalled. a low sample while idle opens a half-bit wait
// (half_bit_ticks ticks); if the line is still low there the start bit counts,
// and every full bit period (twice half_bit_ticks, zero acts as one) one data
// bit is taken, least significant first, then the parity bit when parity_mode
// is even or odd, then the stop bit. at the stop sample the byte, a parity
// mismatch flag and the raw stop level go into a short queue; the output stage
// takes them from there into its register. the stop level is reported,
// never checked. data_bit_count below 5 acts as 5, above 8 as 8; parity_mode 3
// means no parity. configuration is written through cfg_we/cfg_index/cfg_data
// and should only change while the receiver is idle.
module uart_receiver_with_parity
  import uart_rx_pkg::*;
#(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  uart_rx_in_if.sink            in_ch,
  uart_rx_out_if.source         out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  rx_cfg_t    cfg_r;
  rx_push_t   push;
  rx_result_t q_head;
  logic       q_full, q_not_empty, q_pop;
  logic       beat;

  // configuration registers, written in place, no read-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_bit_ticks <= HALF_RESET;
      cfg_r.data_bit_count <= BITS_RESET;
      cfg_r.parity_mode    <= PAR_EVEN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HALF_BIT_TICKS: cfg_r.half_bit_ticks <= cfg_data;
        CFG_DATA_BIT_COUNT: cfg_r.data_bit_count <= cfg_data[BITS_W-1:0];
        CFG_PARITY_MODE:    cfg_r.parity_mode    <= cfg_data[PMODE_W-1:0];
        default: ;
      endcase
    end
  end

  // a line sample is taken whenever the queue can absorb a frame result
  assign in_ch.ready = !q_full;
  assign beat        = in_ch.valid && in_ch.ready;

  // front: bit timing and frame assembly
  uart_rx_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat       (beat),
    .line_level (in_ch.line_level),
    .cfg        (cfg_r),
    .push       (push)
  );

  // queue decoupling sampler from output handshake
  uart_rx_fifo #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // back: registered result channel
  uart_rx_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_ch      (out_ch)
  );

endmodule

### bench/uart_receiver_with_parity_tb.sv
`timescale 1ns / 100ps

module uart_receiver_with_parity_tb;
  import uart_rx_pkg::*;

  // parity code the block treats as no parity
  localparam logic [PMODE_W-1:0] PAR_RESERVED = 2'd3;

  // stimulus sizing
  localparam int unsigned RANDOM_BEATS  = 450;
  // slack after the last owed frame has left the output register
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned END_CYCLES    = 12;
  // receiver hold-off long enough to fill the result queue at the fastest rate
  localparam int unsigned LONG_HOLD     = 200;
  // cycles with no beat on any port before the run is called hung
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned MAX_REPORTS   = 10;

  typedef enum logic [2:0] {
    LINE_IDLE   = 3'd0,
    LINE_START  = 3'd1,
    LINE_DATA   = 3'd2,
    LINE_PARITY = 3'd3,
    LINE_STOP   = 3'd4
  } line_phase_t;

  // tracks the receive line beat by beat and holds the frames still owed
  class rx_frame_checker;
    logic [HALF_W-1:0]  half_ticks;
    logic [BITS_W-1:0]  bit_count;
    logic [PMODE_W-1:0] pmode;
    line_phase_t        phase;
    logic [TICK_W-1:0]  tick_cnt;
    logic [3:0]         bit_idx;
    logic [BYTE_W-1:0]  shift_reg;
    logic               par_acc;
    logic               par_rx;
    rx_result_t         pending_frames[$];
    int unsigned        errors;
    int unsigned        frames_seen;

    function new();
      half_ticks  = HALF_RESET;
      bit_count   = BITS_RESET;
      pmode       = PAR_EVEN;
      phase       = LINE_IDLE;
      tick_cnt    = '0;
      bit_idx     = '0;
      shift_reg   = '0;
      par_acc     = 1'b0;
      par_rx      = 1'b0;
      errors      = 0;
      frames_seen = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_HALF_BIT_TICKS: half_ticks = val[HALF_W-1:0];
        CFG_DATA_BIT_COUNT: bit_count  = val[BITS_W-1:0];
        CFG_PARITY_MODE:    pmode      = val[PMODE_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned half_period();
      int unsigned h;
      h = 32'(half_ticks);
      return (h == 0) ? 1 : h;
    endfunction

    function int unsigned frame_bits();
      if (bit_count < BITS_MIN) return 32'(BITS_MIN);
      if (bit_count > BITS_MAX) return 32'(BITS_MAX);
      return 32'(bit_count);
    endfunction

    function bit parity_enabled();
      return (pmode == PAR_EVEN) || (pmode == PAR_ODD);
    endfunction

    function bit line_idle();
      return phase == LINE_IDLE;
    endfunction

    function int unsigned pending_count();
      return pending_frames.size();
    endfunction

    function bit tick_reached(int unsigned target);
      tick_cnt = tick_cnt + TICK_W'(1);
      if ({15'd0, tick_cnt} >= target) begin
        tick_cnt = '0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_beat(logic level);
      rx_result_t frame;
      logic       want_par;
      case (phase)
        LINE_START: begin
          if (tick_reached(half_period())) begin
            if (level == 1'b0) begin
              phase     = LINE_DATA;
              bit_idx   = '0;
              shift_reg = '0;
              par_acc   = 1'b0;
            end else begin
              phase = LINE_IDLE;
            end
          end
        end
        LINE_DATA: begin
          if (tick_reached(2 * half_period())) begin
            if (bit_idx < 4'd8)
              shift_reg = shift_reg | (BYTE_W'(level) << bit_idx);
            par_acc = par_acc ^ level;
            bit_idx = bit_idx + 4'd1;
            if (32'(bit_idx) >= frame_bits())
              phase = parity_enabled() ? LINE_PARITY : LINE_STOP;
          end
        end
        LINE_PARITY: begin
          if (tick_reached(2 * half_period())) begin
            par_rx = level;
            phase  = LINE_STOP;
          end
        end
        LINE_STOP: begin
          if (tick_reached(2 * half_period())) begin
            frame.received_byte = shift_reg;
            frame.frame_status  = 1'b0;
            frame.stop_level    = level;
            if (parity_enabled()) begin
              want_par = (pmode == PAR_ODD) ? ~par_acc : par_acc;
              frame.frame_status = (want_par != par_rx);
            end
            pending_frames.push_back(frame);
            phase = LINE_IDLE;
          end
        end
        default: begin
          phase = LINE_IDLE;
          if (level == 1'b0) begin
            phase    = LINE_START;
            tick_cnt = '0;
          end
        end
      endcase
    endfunction

    function void flag_error(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("%s", msg);
    endfunction

    function void check_frame(logic [BYTE_W-1:0] got_byte, logic got_status, logic got_stop);
      rx_result_t want;
      frames_seen++;
      if (pending_frames.size() == 0) begin
        flag_error($sformatf("frame %0d not expected: byte %02h status %0b stop %0b",
                             frames_seen, got_byte, got_status, got_stop));
        return;
      end
      want = pending_frames.pop_front();
      if (want.received_byte !== got_byte || want.frame_status !== got_status ||
          want.stop_level !== got_stop)
        flag_error($sformatf({"frame %0d wrong: expected byte %02h status %0b stop %0b,",
                              " got byte %02h status %0b stop %0b"},
                             frames_seen, want.received_byte, want.frame_status,
                             want.stop_level, got_byte, got_status, got_stop));
    endfunction

    function int unsigned close_out();
      rx_result_t want;
      while (pending_frames.size() != 0) begin
        want = pending_frames.pop_front();
        flag_error($sformatf("frame never came out: byte %02h status %0b stop %0b",
                             want.received_byte, want.frame_status, want.stop_level));
      end
      return errors;
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  uart_rx_in_if  in_bus();
  uart_rx_out_if out_bus();

  uart_receiver_with_parity u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rx_frame_checker sb;
  int unsigned     beat_count;
  int unsigned     stall_cycles;
  // no random gaps on either side while set
  bit              quiet_run;
  // asks the receiver for one long hold-off
  bit              hold_request;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // one line sample per beat; the tick count only moves on accepted beats
  task automatic send_sample(input logic level);
    int unsigned gap;
    gap = quiet_run ? 0 : pick_gap();
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.line_level <= level;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    sb.note_beat(level);
    beat_count++;
  endtask

  task automatic hold_level(input logic level, input int unsigned beats);
    repeat (beats) send_sample(level);
  endtask

  // drive the line high until the receiver is back in idle, then drop valid
  // and wait for every owed frame to come out, then SETTLE_CYCLES more
  task automatic settle();
    while (!sb.line_idle()) send_sample(1'b1);
    in_bus.valid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // half period only, the other registers keep their values
  task automatic set_half_period(input logic [HALF_W-1:0] half);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_HALF_BIT_TICKS;
    cfg_data  <= CFG_DATA_W'(half);
    @(posedge clk);
    sb.write_reg(CFG_HALF_BIT_TICKS, CFG_DATA_W'(half));
    cfg_we <= 1'b0;
  endtask

  // all three registers, one per cycle, only once the receiver is idle
  task automatic set_config(input logic [HALF_W-1:0] half, input logic [BITS_W-1:0] bits,
                            input logic [PMODE_W-1:0] mode);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_HALF_BIT_TICKS;
    cfg_data  <= CFG_DATA_W'(half);
    @(posedge clk);
    sb.write_reg(CFG_HALF_BIT_TICKS, CFG_DATA_W'(half));
    cfg_index <= CFG_DATA_BIT_COUNT;
    cfg_data  <= CFG_DATA_W'(bits);
    @(posedge clk);
    sb.write_reg(CFG_DATA_BIT_COUNT, CFG_DATA_W'(bits));
    cfg_index <= CFG_PARITY_MODE;
    cfg_data  <= CFG_DATA_W'(mode);
    @(posedge clk);
    sb.write_reg(CFG_PARITY_MODE, CFG_DATA_W'(mode));
    cfg_we <= 1'b0;
  endtask

  // whole frame at the current settings, each bit held one full bit period
  task automatic send_frame(input logic [7:0] data, input bit bad_parity,
                            input logic stop_lvl, input int unsigned lead);
    int unsigned bit_beats;
    logic        par;
    bit_beats = 2 * sb.half_period();
    par = 1'b0;
    hold_level(1'b1, lead);
    hold_level(1'b0, bit_beats);
    for (int j = 0; j < sb.frame_bits(); j++) begin
      hold_level(data[j], bit_beats);
      par = par ^ data[j];
    end
    if (sb.parity_enabled()) begin
      if (sb.pmode == PAR_ODD) par = ~par;
      hold_level(par ^ bad_parity, bit_beats);
    end
    hold_level(stop_lvl, bit_beats);
  endtask

  task automatic send_noise();
    int unsigned half;
    half = sb.half_period();
    case ($urandom_range(0, 2))
      0: begin
        // raw random samples
        repeat ($urandom_range(1, 20)) send_sample(1'($urandom_range(0, 1)));
      end
      1: begin
        // false start: line back high before the half-bit point
        hold_level(1'b0, $urandom_range(1, half));
        hold_level(1'b1, 2 * half);
      end
      default: begin
        // frame cut off after some or all of its data bits
        hold_level(1'b0, 2 * half);
        repeat ($urandom_range(1, sb.frame_bits()))
          hold_level(1'($urandom_range(0, 1)), 2 * half);
      end
    endcase
  endtask

  // receiver side: random stalls, quiet stretches, and the long hold-off
  initial begin
    int unsigned r;
    out_bus.ready = 1'b0;
    @(posedge clk iff rst_n === 1'b1);
    forever begin
      r = $urandom_range(0, 99);
      if (hold_request) begin
        out_bus.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_request = 1'b0;
      end else if (!quiet_run && r >= 97) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(10, 40)) @(posedge clk);
      end else if (!quiet_run && r >= 75) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_bus.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // result beats are compared against the oldest owed frame
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1)
      sb.check_frame(out_bus.received_byte, out_bus.frame_status, out_bus.stop_level);
  end

  // hang detector: counts cycles with no beat on any port
  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst_n !== 1'b1 || cfg_we === 1'b1 ||
          (in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
          (out_bus.valid === 1'b1 && out_bus.ready === 1'b1))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int unsigned        r;
    int unsigned        random_start;
    logic [HALF_W-1:0]  h_pick;
    logic [BITS_W-1:0]  b_pick;
    logic [PMODE_W-1:0] p_pick;

    sb                = new();
    beat_count        = 0;
    quiet_run         = 1'b0;
    hold_request      = 1'b0;
    rst_n             = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.line_level = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = CFG_HALF_BIT_TICKS;
    cfg_data          = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed part ---
    // data bit count and parity mode left at reset, short bit period, no gaps
    set_half_period(16'd1);
    quiet_run = 1'b1;
    send_frame(8'hA5, 1'b0, 1'b1, 2);
    quiet_run = 1'b0;

    // fastest rate, even parity: byte extremes and a parity error
    set_config(16'd1, BITS_MAX, PAR_EVEN);
    send_frame(8'h00, 1'b0, 1'b1, 1);
    send_frame(8'hFF, 1'b0, 1'b1, 0);
    send_frame(8'h5A, 1'b1, 1'b1, 1);

    // odd parity, good and bad
    set_config(16'd1, BITS_MAX, PAR_ODD);
    send_frame(8'h3C, 1'b0, 1'b1, 1);
    send_frame(8'hC3, 1'b1, 1'b1, 1);

    // no parity, and the reserved mode that acts as none
    set_config(16'd2, BITS_MAX, PAR_NONE);
    send_frame(8'h81, 1'b0, 1'b1, 1);
    set_config(16'd1, BITS_MAX, PAR_RESERVED);
    send_frame(8'h7E, 1'b0, 1'b1, 1);

    // data bit counts: minimum, below range, above range
    set_config(16'd1, BITS_MIN, PAR_EVEN);
    send_frame(8'hFF, 1'b0, 1'b1, 1);
    set_config(16'd1, 4'd0, PAR_ODD);
    send_frame(8'h15, 1'b1, 1'b1, 1);
    set_config(16'd1, 4'd15, PAR_NONE);
    send_frame(8'hB6, 1'b0, 1'b1, 1);

    // zero half period runs like one, seven data bits
    set_config(16'd0, 4'd7, PAR_EVEN);
    send_frame(8'h6D, 1'b0, 1'b1, 1);

    // false start, then a low stop bit that runs into a new frame
    set_config(16'd2, BITS_MAX, PAR_EVEN);
    hold_level(1'b0, 1);
    hold_level(1'b1, 4);
    send_frame(8'h99, 1'b0, 1'b0, 1);
    send_frame(8'h42, 1'b0, 1'b1, 3);

    // --- back pressure: receiver holds off while frames keep coming ---
    set_config(16'd1, BITS_MAX, PAR_EVEN);
    quiet_run    = 1'b1;
    hold_request = 1'b1;
    repeat (12) send_frame(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0, 1'b1, 0);
    quiet_run = 1'b0;
    // sender pauses until the queue has fully drained
    settle();

    // --- random part: settings change between bursts of frames ---
    random_start = beat_count;
    while (beat_count - random_start < RANDOM_BEATS) begin
      r = $urandom_range(0, 99);
      if (r < 55)      h_pick = HALF_W'($urandom_range(1, 3));
      else if (r < 70) h_pick = '0;
      else if (r < 95) h_pick = HALF_W'($urandom_range(4, 8));
      else             h_pick = HALF_W'($urandom_range(9, 20));
      b_pick = ($urandom_range(0, 3) == 0) ? BITS_W'($urandom_range(0, 15)) :
                                             BITS_W'($urandom_range(5, 8));
      p_pick = PMODE_W'($urandom_range(0, 3));
      set_config(h_pick, b_pick, p_pick);
      quiet_run = ($urandom_range(0, 5) == 0);
      repeat ($urandom_range(3, 8)) begin
        if (beat_count - random_start >= RANDOM_BEATS) break;
        // mostly well-formed frames, the rest noise and broken frames
        if ($urandom_range(0, 99) < 85)
          send_frame(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                     $urandom_range(0, 9) != 0, $urandom_range(0, 3));
        else
          send_noise();
      end
      quiet_run = 1'b0;
    end

    // --- wind down: every owed frame out, then a little slack ---
    settle();
    repeat (END_CYCLES) @(posedge clk);
    if (sb.close_out() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
